// File: sv/bddd_pkg.sv
package bddd_pkg;

    // Operation codes carried in the input tuser field.
    localparam logic [2:0] OP_PUBLISH_COPY  = 3'd0;
    localparam logic [2:0] OP_PUBLISH_BURST = 3'd1;
    localparam logic [2:0] OP_BUMP          = 3'd2;
    localparam logic [2:0] OP_CANCEL        = 3'd3;
    localparam logic [2:0] OP_CANCEL_SCENE  = 3'd4;
    localparam logic [2:0] OP_TICK          = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] REG_TICK_BUDGET     = 2'd0;
    localparam logic [1:0] REG_STOP_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_SCENE_SLOT_MASK = 2'd2;

    localparam logic [7:0] TICK_BUDGET_RESET    = 8'd32;
    localparam logic [7:0] STOP_THRESHOLD_RESET = 8'd3;
    localparam int         SCENE_MASK_BITS      = 6;

    // Command queue between front and back end; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Width used to widen slot compares against SLOTS.
    localparam int SLOT_CMP_W = 5;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  slot;
        logic [23:0] src_addr;
        logic [15:0] dst_addr;
        logic [15:0] length;
        logic [15:0] stride;
        logic [7:0]  chunk_count;
        logic [7:0]  chunk_cost;
        logic        fire_enable;
    } item_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  slot;
        logic [23:0] src_addr;
        logic [15:0] dst_addr;
        logic [15:0] length;
        logic [15:0] stride;
        logic [7:0]  chunk_count;
        logic [7:0]  chunk_cost;
    } entry_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  slot;
        logic [23:0] src;
        logic [15:0] dst;
        logic [15:0] length;
        logic [15:0] mode;
    } cmd_t;

endpackage

// File: sv/bddd_front.sv
module bddd_front #(
    parameter int SLOTS = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bddd_pkg::item_t  in_item,
    output logic             q_valid,
    output bddd_pkg::entry_t q_entry,
    input  logic             q_pop
);

    bddd_pkg::entry_t entry_reg [bddd_pkg::QUEUE_DEPTH];

    logic [bddd_pkg::QUEUE_PW-1:0] wr_ptr_reg;
    logic [bddd_pkg::QUEUE_PW-1:0] rd_ptr_reg;
    logic [bddd_pkg::QUEUE_CW-1:0] count_reg;

    logic keep;
    logic push;
    logic pop;

    // Items that cannot change state are taken and dropped here.
    always_comb
    begin
        unique case (in_item.op) inside
            bddd_pkg::OP_PUBLISH_COPY, bddd_pkg::OP_PUBLISH_BURST,
            bddd_pkg::OP_BUMP, bddd_pkg::OP_CANCEL:
                keep = bddd_pkg::SLOT_CMP_W'(in_item.slot) < bddd_pkg::SLOT_CMP_W'(SLOTS);
            bddd_pkg::OP_CANCEL_SCENE:
                keep = 1'b1;
            bddd_pkg::OP_TICK:
                keep = in_item.fire_enable;
            default:
                keep = 1'b0;
        endcase
    end

    assign in_ready = count_reg != bddd_pkg::QUEUE_CW'(bddd_pkg::QUEUE_DEPTH);
    assign push     = in_valid && in_ready && keep;
    assign pop      = q_pop && q_valid;
    assign q_valid  = count_reg != '0;
    assign q_entry  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{
                op:          in_item.op,
                slot:        in_item.slot,
                src_addr:    in_item.src_addr,
                dst_addr:    in_item.dst_addr,
                length:      in_item.length,
                stride:      in_item.stride,
                chunk_count: in_item.chunk_count,
                chunk_cost:  in_item.chunk_cost
            };
        end
    end

endmodule

// File: sv/bddd_engine.sv
module bddd_engine #(
    parameter int SLOTS     = 6,
    parameter int MAX_FIRES = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  bddd_pkg::entry_t q_entry,
    output logic             q_pop,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_addr,
    input  logic [7:0]       cfg_wdata,
    output logic             out_valid,
    input  logic             out_ready,
    output bddd_pkg::cmd_t   out_cmd,
    output logic             out_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int NW = $clog2(MAX_FIRES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // Configuration.
    logic [7:0] tick_budget_reg;
    logic [7:0] stop_threshold_reg;
    logic [bddd_pkg::SCENE_MASK_BITS-1:0] scene_mask_reg;

    // Descriptor table.
    logic [23:0] src_reg      [SLOTS];
    logic [15:0] dst_reg      [SLOTS];
    logic [15:0] len_reg      [SLOTS];
    logic [15:0] stride_reg   [SLOTS];
    logic        burst_reg    [SLOTS];
    logic [7:0]  remain_reg   [SLOTS];
    logic [7:0]  cost_reg     [SLOTS];
    logic [7:0]  snap_reg     [SLOTS];
    logic [7:0]  seq_reg      [SLOTS];
    logic [SLOTS-1:0] ready_reg;

    // Walk control.
    logic [1:0]    state_reg;
    logic [CW-1:0] idx_reg;
    logic [7:0]    left_reg;
    logic [NW-1:0] fires_reg;

    // One command is held back until it is known whether it ends the tick.
    logic           hold_valid_reg;
    bddd_pkg::cmd_t hold_reg;
    logic           out_valid_reg;
    bddd_pkg::cmd_t out_cmd_reg;
    logic           out_last_reg;

    logic [IW-1:0] cur;
    logic [IW-1:0] wslot;
    logic          in_range;
    logic          cur_ready;
    logic          cur_stale;
    logic          can_emit;
    logic          out_free;
    logic          emit_go;
    logic          flush_go;
    logic          stop_walk;
    logic [15:0]   scene_wide;
    bddd_pkg::cmd_t new_cmd;

    assign cur      = idx_reg[IW-1:0];
    assign wslot    = IW'(q_entry.slot);
    assign in_range = idx_reg < CW'(SLOTS);
    assign cur_ready = in_range && ready_reg[cur];
    assign cur_stale = snap_reg[cur] != seq_reg[cur];
    assign can_emit = cur_ready && !cur_stale && (remain_reg[cur] != 8'd0)
                      && (cost_reg[cur] <= left_reg) && (fires_reg < NW'(MAX_FIRES));
    assign out_free = !out_valid_reg || out_ready;
    assign emit_go  = (state_reg == ST_WALK) && can_emit && (!hold_valid_reg || out_free);
    assign flush_go = (state_reg == ST_FLUSH) && hold_valid_reg && out_free;
    assign stop_walk = (fires_reg >= NW'(MAX_FIRES)) || (left_reg < stop_threshold_reg);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign scene_wide = 16'(scene_mask_reg);

    always_comb
    begin
        new_cmd.kind   = burst_reg[cur];
        new_cmd.slot   = 3'(cur);
        new_cmd.src    = burst_reg[cur] ? 24'd0 : src_reg[cur];
        new_cmd.dst    = dst_reg[cur];
        new_cmd.length = len_reg[cur];
        new_cmd.mode   = burst_reg[cur] ? stride_reg[cur] : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_budget_reg    <= bddd_pkg::TICK_BUDGET_RESET;
            stop_threshold_reg <= bddd_pkg::STOP_THRESHOLD_RESET;
            scene_mask_reg     <= '0;
            state_reg          <= ST_IDLE;
            idx_reg            <= '0;
            left_reg           <= '0;
            fires_reg          <= '0;
            ready_reg          <= '0;
            hold_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                seq_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    bddd_pkg::REG_TICK_BUDGET:     tick_budget_reg    <= cfg_wdata;
                    bddd_pkg::REG_STOP_THRESHOLD:  stop_threshold_reg <= cfg_wdata;
                    bddd_pkg::REG_SCENE_SLOT_MASK:
                        scene_mask_reg <= cfg_wdata[bddd_pkg::SCENE_MASK_BITS-1:0];
                    default: ;
                endcase
            end

            if (out_free)
            begin
                out_valid_reg <= (emit_go && hold_valid_reg) || flush_go;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        case (q_entry.op)
                            bddd_pkg::OP_PUBLISH_COPY,
                            bddd_pkg::OP_PUBLISH_BURST:
                                ready_reg[wslot] <= 1'b1;
                            bddd_pkg::OP_BUMP:
                                seq_reg[wslot] <= seq_reg[wslot] + 8'd1;
                            bddd_pkg::OP_CANCEL:
                                ready_reg[wslot] <= 1'b0;
                            bddd_pkg::OP_CANCEL_SCENE:
                            begin
                                for (int i = 0; i < SLOTS; i++)
                                begin
                                    if (scene_wide[i])
                                    begin
                                        ready_reg[i] <= 1'b0;
                                    end
                                end
                            end
                            bddd_pkg::OP_TICK:
                            begin
                                idx_reg   <= '0;
                                left_reg  <= tick_budget_reg;
                                fires_reg <= '0;
                                state_reg <= ST_WALK;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WALK:
                begin
                    if (!in_range)
                    begin
                        state_reg <= ST_FLUSH;
                    end
                    else if (!ready_reg[cur])
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (cur_stale)
                    begin
                        ready_reg[cur] <= 1'b0;
                        idx_reg        <= idx_reg + 1'b1;
                    end
                    else if (can_emit)
                    begin
                        if (emit_go)
                        begin
                            left_reg       <= left_reg - cost_reg[cur];
                            fires_reg      <= fires_reg + 1'b1;
                            hold_valid_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        // The slot is finished for this tick.
                        if (remain_reg[cur] == 8'd0)
                        begin
                            ready_reg[cur] <= 1'b0;
                        end
                        if (stop_walk)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (!hold_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        hold_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Descriptor payload and command data.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            if (q_entry.op == bddd_pkg::OP_PUBLISH_COPY)
            begin
                burst_reg[wslot]  <= 1'b0;
                src_reg[wslot]    <= q_entry.src_addr;
                remain_reg[wslot] <= q_entry.chunk_count;
            end
            if (q_entry.op == bddd_pkg::OP_PUBLISH_BURST)
            begin
                burst_reg[wslot]  <= 1'b1;
                remain_reg[wslot] <= 8'd1;
            end
            if (q_entry.op == bddd_pkg::OP_PUBLISH_COPY
                || q_entry.op == bddd_pkg::OP_PUBLISH_BURST)
            begin
                dst_reg[wslot]    <= q_entry.dst_addr;
                len_reg[wslot]    <= q_entry.length;
                stride_reg[wslot] <= q_entry.stride;
                cost_reg[wslot]   <= q_entry.chunk_cost;
                snap_reg[wslot]   <= seq_reg[wslot];
            end
        end

        if (emit_go)
        begin
            hold_reg <= new_cmd;
            if (burst_reg[cur])
            begin
                remain_reg[cur] <= 8'd0;
            end
            else
            begin
                src_reg[cur]    <= src_reg[cur] + {8'd0, len_reg[cur]};
                dst_reg[cur]    <= dst_reg[cur] + stride_reg[cur];
                remain_reg[cur] <= remain_reg[cur] - 8'd1;
            end
        end

        if (emit_go && hold_valid_reg && out_free)
        begin
            out_cmd_reg  <= hold_reg;
            out_last_reg <= 1'b0;
        end
        else if (flush_go)
        begin
            out_cmd_reg  <= hold_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cmd   = out_cmd_reg;
    assign out_last  = out_last_reg;

endmodule

// File: sv/budgeted_dma_descriptor_dispatcher.sv
// An item is registered in the front-end queue and is popped by the back end when it is idle;
// a table op is applied as it is popped. A tick loads the budget, visits each slot in order,
// emits commands as the budget allows, steps past the last slot only when the walk reaches the
// end, and closes in the flush state; the single walk sequencer over the descriptor table sets this.
// A command is held until the next one is chosen or the walk closes, then registered to the output.
// Reset is asynchronous and active low: all tokens and sequences clear, registers take defaults.
module budgeted_dma_descriptor_dispatcher #(
    parameter int SLOTS     = 6,
    parameter int MAX_FIRES = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    // Input items. tuser: op[2:0].
    // tdata from bit 0: slot[2:0], src_addr[23:0], dst_addr[15:0], length[15:0],
    // stride[15:0], chunk_count[7:0], chunk_cost[7:0], fire_enable, zero fill[3:0].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,

    // Transfer commands. tuser: cmd_kind. tlast: last command of the tick.
    // tdata from bit 0: cmd_slot[2:0], cmd_src[23:0], cmd_dst[15:0], cmd_length[15:0],
    // cmd_mode[15:0], zero fill[4:0].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,

    // Configuration writes: 0 tick_budget, 1 stop_threshold, 2 scene_slot_mask.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    bddd_pkg::item_t  in_item;
    bddd_pkg::entry_t q_entry;
    bddd_pkg::cmd_t   out_cmd;
    logic             q_valid;
    logic             q_pop;

    // Unpack the input transfer.
    always_comb
    begin
        in_item.op          = s_axis_tuser;
        in_item.slot        = s_axis_tdata[2:0];
        in_item.src_addr    = s_axis_tdata[26:3];
        in_item.dst_addr    = s_axis_tdata[42:27];
        in_item.length      = s_axis_tdata[58:43];
        in_item.stride      = s_axis_tdata[74:59];
        in_item.chunk_count = s_axis_tdata[82:75];
        in_item.chunk_cost  = s_axis_tdata[90:83];
        in_item.fire_enable = s_axis_tdata[91];
    end

    // The front end decodes items and drops those that change nothing, then queues the rest so
    // that new items are taken while the back end walks the table.
    bddd_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    // The back end owns the descriptor table and the budget walk, and holds one command back so
    // that the final command of a tick carries tlast.
    bddd_engine #(
        .SLOTS     (SLOTS),
        .MAX_FIRES (MAX_FIRES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_cmd   (out_cmd),
        .out_last  (m_axis_tlast)
    );

    // Pack the output transfer.
    assign m_axis_tuser = out_cmd.kind;
    assign m_axis_tdata = {5'd0, out_cmd.mode, out_cmd.length, out_cmd.dst,
                           out_cmd.src, out_cmd.slot};

endmodule
